// ===== hdl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock face row renderer package
// Shared constants, glyph tables, digit split and the draw context type.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int MODULES   = 3;
   localparam int ROWS      = MODULES * 8;
   localparam int ROW_IDX_W = $clog2(ROWS);

   localparam logic [1:0] CMD_TIME  = 2'd0;
   localparam logic [1:0] CMD_ALARM = 2'd1;
   localparam logic [1:0] CMD_BLINK = 2'd2;

   localparam logic ACT_ROW   = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic REG_BLINK_INTERVAL = 1'b0;
   localparam logic REG_FONT_STYLE     = 1'b1;

   localparam logic [31:0] BLINK_INTERVAL_RESET = 32'd500000;
   localparam logic        FONT_STYLE_RESET     = 1'b1;

   typedef struct packed {
      logic       alarm;
      logic       alarm_on;
      logic       font;
      logic       blank_tens;
      logic [3:0] hour_tens;
      logic [3:0] hour_ones;
      logic [3:0] min_tens;
      logic [3:0] min_ones;
   } draw_ctx_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digit_pair_type;

   localparam logic [7:0] DIGIT_GLYPH [2][10][5] = '{
      '{
         '{8'h1F, 8'h21, 8'h42, 8'h84, 8'hF8},
         '{8'h20, 8'h23, 8'h4C, 8'h70, 8'hC0},
         '{8'h21, 8'h47, 8'hCA, 8'h72, 8'h04},
         '{8'h20, 8'h40, 8'h89, 8'hB2, 8'hCC},
         '{8'h18, 8'h68, 8'h93, 8'h3C, 8'h10},
         '{8'h32, 8'h49, 8'h51, 8'h91, 8'h0E},
         '{8'h0C, 8'h32, 8'h49, 8'h8A, 8'h04},
         '{8'h43, 8'h8C, 8'h90, 8'hA0, 8'hC0},
         '{8'h07, 8'h69, 8'h91, 8'hAE, 8'hC0},
         '{8'h01, 8'h61, 8'h96, 8'h98, 8'h60}
      },
      '{
         '{8'h00, 8'hFF, 8'h81, 8'hFF, 8'h00},
         '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00},
         '{8'h00, 8'h9F, 8'h91, 8'hF1, 8'h00},
         '{8'h00, 8'h91, 8'h91, 8'hFF, 8'h00},
         '{8'h00, 8'hF0, 8'h10, 8'hFF, 8'h00},
         '{8'h00, 8'hF1, 8'h91, 8'h9F, 8'h00},
         '{8'h00, 8'hFF, 8'h91, 8'h9F, 8'h00},
         '{8'h00, 8'h80, 8'h80, 8'hFF, 8'h00},
         '{8'h00, 8'hFF, 8'h91, 8'hFF, 8'h00},
         '{8'h00, 8'hF0, 8'h90, 8'hFF, 8'h00}
      }
   };

   localparam logic [7:0] ICON_GLYPH [9] = '{
      8'h40, 8'hB9, 8'h55, 8'h92, 8'hB2, 8'h82, 8'h45, 8'hB9, 8'h40
   };

   localparam logic [7:0] STATE_GLYPH [2][15] = '{
      '{8'h00, 8'h1C, 8'h22, 8'h42, 8'h44, 8'h38, 8'h00, 8'h02,
        8'h3C, 8'h50, 8'h40, 8'h02, 8'h3C, 8'h50, 8'h40},
      '{8'h00, 8'h1C, 8'h22, 8'h42, 8'h44, 8'h38, 8'h00, 8'h00,
        8'h1E, 8'h60, 8'h18, 8'h06, 8'h78, 8'h00, 8'h00}
   };

   function automatic digit_pair_type split_digits(input logic [5:0] v);
      digit_pair_type res;
      logic [5:0]     rem;
      rem = v;
      priority if (v >= 6'd50) begin
         res.tens = 4'd5;
         rem      = v - 6'd50;
      end else if (v >= 6'd40) begin
         res.tens = 4'd4;
         rem      = v - 6'd40;
      end else if (v >= 6'd30) begin
         res.tens = 4'd3;
         rem      = v - 6'd30;
      end else if (v >= 6'd20) begin
         res.tens = 4'd2;
         rem      = v - 6'd20;
      end else if (v >= 6'd10) begin
         res.tens = 4'd1;
         rem      = v - 6'd10;
      end else begin
         res.tens = 4'd0;
      end
      res.ones = rem[3:0];
      return res;
   endfunction

endpackage

// ===== hdl/clock_face_row_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// Clock face row renderer
// Renders time, alarm status and blink phases for a 24x8 LED matrix of three
// 8x8 modules and emits only the rows that differ from the displayed image, or module clears to blank it.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (show time, show alarm, blink tick).
//   req_ready is high only while the sequencer is idle; one item is handled
//   at a time. rsp_* carries row writes and module clears, rsp_last marks the
//   final result of an item. csr_* writes blink_interval (index 0) and
//   font_style (index 1) with no wait. The user is to write them only while
//   the block is idle; the block itself does not enforce this.
// A draw passes accept, decode, a scan of all 24 rows (one row built and
// compared per cycle by the shared row generator unless the scan holds)
// and flush. A blink toggle to blank clears the three modules in turn; a
// blink tick that does not toggle, or an unused command, returns to idle.
// A changed row is held until the next changed row or the flush step
// settles its last flag; it then goes to the output register.
// Reset clears the mirror of displayed rows, the blink phase, the last
// toggle time and both registers to their defaults.
// A stalled receiver holds the output register; the scan then holds at the
// next changed row until the output register frees.
// ----------------------------------------------------------------------------
module clock_face_row_renderer_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [4:0]  req_hours,
   input  logic [5:0]  req_minutes,
   input  logic        req_alarm_on,
   input  logic [31:0] req_now_us,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_action,
   output logic [1:0]  rsp_module_res,
   output logic [2:0]  rsp_row,
   output logic [7:0]  rsp_row_data,
   output logic        rsp_last,

   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = cfr_pkg::ROW_IDX_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FLUSH  = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] interval_ff, interval_in;
   logic        font_ff, font_in;
   logic        showing_ff, showing_in;
   logic [31:0] last_edge_ff, last_edge_in;
   logic [7:0]  mirror_ff [cfr_pkg::ROWS];
   logic [7:0]  mirror_in [cfr_pkg::ROWS];
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]  clr_ff, clr_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] now_ff, now_in;
   cfr_pkg::draw_ctx_type ctx_ff, ctx_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [7:0]  pend_data_ff, pend_data_in;
   logic        rsp_action_ff, rsp_action_in;
   logic [1:0]  rsp_module_ff, rsp_module_in;
   logic [2:0]  rsp_row_ff, rsp_row_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [7:0]  row_new;
   logic        out_free;
   logic        row_diff;
   logic [31:0] elapsed;
   cfr_pkg::digit_pair_type hour_dp, min_dp;
   logic [4:0]  hours_sat;
   logic [5:0]  minutes_sat;

   cfr_row_gen u_row_gen (
      .ctx      (ctx_ff),
      .row_idx  (idx_ff),
      .row_bits (row_new)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_module_res = rsp_module_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_row_data   = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign row_diff    = (row_new != mirror_ff[idx_ff]);
   assign elapsed     = now_ff - last_edge_ff;
   assign hours_sat   = (req_hours > 5'd23) ? 5'd23 : req_hours;
   assign minutes_sat = (req_minutes > 6'd59) ? 6'd59 : req_minutes;
   assign hour_dp     = cfr_pkg::split_digits({1'b0, hours_sat});
   assign min_dp      = cfr_pkg::split_digits(minutes_sat);

   always_comb begin
      logic push;
      logic last_step;
      state_in      = state_ff;
      interval_in   = interval_ff;
      font_in       = font_ff;
      showing_in    = showing_ff;
      last_edge_in  = last_edge_ff;
      mirror_in     = mirror_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      pend_valid_in = pend_valid_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      ctx_in        = ctx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_data_in  = pend_data_ff;
      rsp_action_in = rsp_action_ff;
      rsp_module_in = rsp_module_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      push          = 1'b0;
      last_step     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            cfr_pkg::REG_BLINK_INTERVAL: interval_in = csr_wdata;
            cfr_pkg::REG_FONT_STYLE:     font_in     = csr_wdata[0];
            default:                     interval_in = interval_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in              = req_command;
               now_in              = req_now_us;
               ctx_in.alarm        = (req_command == cfr_pkg::CMD_ALARM);
               ctx_in.alarm_on     = req_alarm_on;
               ctx_in.font         = font_ff;
               ctx_in.blank_tens   = (hour_dp.tens == 4'd0);
               ctx_in.hour_tens    = hour_dp.tens;
               ctx_in.hour_ones    = hour_dp.ones;
               ctx_in.min_tens     = min_dp.tens;
               ctx_in.min_ones     = min_dp.ones;
               state_in            = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in   = '0;
            clr_in   = 2'd0;
            state_in = ST_IDLE;
            priority if (cmd_ff == cfr_pkg::CMD_TIME || cmd_ff == cfr_pkg::CMD_ALARM) begin
               state_in = ST_SCAN;
            end else if (cmd_ff == cfr_pkg::CMD_BLINK && elapsed > interval_ff) begin
               last_edge_in = now_ff;
               if (!showing_ff) begin
                  showing_in = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  showing_in = 1'b0;
                  for (int i = 0; i < cfr_pkg::ROWS; i++) begin
                     mirror_in[i] = 8'h00;
                  end
                  state_in = ST_CLEAR;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!(row_diff && pend_valid_ff && !out_free)) begin
               if (row_diff) begin
                  if (pend_valid_ff) begin
                     push          = 1'b1;
                     rsp_action_in = cfr_pkg::ACT_ROW;
                     rsp_module_in = pend_idx_ff[IW-1:3];
                     rsp_row_in    = pend_idx_ff[2:0];
                     rsp_data_in   = pend_data_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in     = 1'b1;
                  pend_idx_in       = idx_ff;
                  pend_data_in      = row_new;
                  mirror_in[idx_ff] = row_new;
               end
               if (idx_ff == IW'(cfr_pkg::ROWS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               rsp_action_in = cfr_pkg::ACT_ROW;
               rsp_module_in = pend_idx_ff[IW-1:3];
               rsp_row_in    = pend_idx_ff[2:0];
               rsp_data_in   = pend_data_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               last_step     = (clr_ff == 2'(cfr_pkg::MODULES - 1));
               push          = 1'b1;
               rsp_action_in = cfr_pkg::ACT_CLEAR;
               rsp_module_in = clr_ff;
               rsp_row_in    = 3'd0;
               rsp_data_in   = 8'h00;
               rsp_last_in   = last_step;
               clr_in        = clr_ff + 2'd1;
               if (last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         interval_ff   <= cfr_pkg::BLINK_INTERVAL_RESET;
         font_ff       <= cfr_pkg::FONT_STYLE_RESET;
         showing_ff    <= 1'b0;
         last_edge_ff  <= 32'd0;
         for (int i = 0; i < cfr_pkg::ROWS; i++) begin
            mirror_ff[i] <= 8'h00;
         end
         idx_ff        <= '0;
         clr_ff        <= 2'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         interval_ff   <= interval_in;
         font_ff       <= font_in;
         showing_ff    <= showing_in;
         last_edge_ff  <= last_edge_in;
         mirror_ff     <= mirror_in;
         idx_ff        <= idx_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      ctx_ff        <= ctx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_data_ff  <= pend_data_in;
      rsp_action_ff <= rsp_action_in;
      rsp_module_ff <= rsp_module_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== hdl/cfr_row_gen.sv =====
// ----------------------------------------------------------------------------
// Clock face row generator
// Builds one 8-pixel display row from the draw context by picking the glyph
// column byte of each of the row's eight columns.
// ----------------------------------------------------------------------------
module cfr_row_gen (
   input  cfr_pkg::draw_ctx_type          ctx,
   input  logic [cfr_pkg::ROW_IDX_W-1:0]  row_idx,
   output logic [7:0]                     row_bits
);

   function automatic logic [7:0] col_byte(input cfr_pkg::draw_ctx_type c,
                                           input logic [4:0] col);
      logic [4:0] off;
      logic [7:0] res;
      res = 8'h00;
      off = 5'd0;
      if (c.alarm) begin
         if (col < 5'd9) begin
            res = cfr_pkg::ICON_GLYPH[col[3:0]];
         end else begin
            off = col - 5'd9;
            res = cfr_pkg::STATE_GLYPH[c.alarm_on][off[3:0]];
         end
      end else begin
         priority if (col < 5'd5) begin
            if (!c.blank_tens) begin
               res = cfr_pkg::DIGIT_GLYPH[c.font][c.hour_tens][col[2:0]];
            end
         end else if (col >= 5'd6 && col < 5'd11) begin
            off = col - 5'd6;
            res = cfr_pkg::DIGIT_GLYPH[c.font][c.hour_ones][off[2:0]];
         end else if (col >= 5'd13 && col < 5'd18) begin
            off = col - 5'd13;
            res = cfr_pkg::DIGIT_GLYPH[c.font][c.min_tens][off[2:0]];
         end else if (col >= 5'd19) begin
            off = col - 5'd19;
            res = cfr_pkg::DIGIT_GLYPH[c.font][c.min_ones][off[2:0]];
         end else begin
            res = 8'h00;
         end
      end
      return res;
   endfunction

   always_comb begin
      logic [4:0] col;
      logic [7:0] cb;
      row_bits = 8'h00;
      for (int c = 0; c < 8; c++) begin
         col = {row_idx[4:3], 3'(c)};
         cb  = col_byte(ctx, col);
         row_bits[3'(7 - c)] = cb[~row_idx[2:0]];
      end
   end

endmodule

// ===== hdl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// Clock face row renderer checker
// Port-level properties of the renderer, bound onto the renderer module.
// ----------------------------------------------------------------------------
module cfr_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_action,
   input logic [1:0]  rsp_module_res,
   input logic [2:0]  rsp_row,
   input logic [7:0]  rsp_row_data,
   input logic        rsp_last
);

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("renderer took a second item right after an accept");

   clear_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == cfr_pkg::ACT_CLEAR
         |-> rsp_row == 3'd0 && rsp_row_data == 8'h00)
      else $error("module clear carries row or pixel data");

   first_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == cfr_pkg::ACT_CLEAR && rsp_module_res != 2'd2
         |-> !rsp_last)
      else $error("clear sequence ended before the last module");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_module_res)
         && $stable(rsp_row) && $stable(rsp_row_data) && $stable(rsp_last))
      else $error("stalled result item changed");

endmodule

bind clock_face_row_renderer_unit cfr_port_props u_cfr_port_props (.*);

// ===== test/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// Clock face row renderer checker
// Watches the request, result and register ports of the renderer, keeps its
// own model of the displayed image, blink phase and registers, predicts the
// row writes and module clears of every accepted item, and compares each
// result field by field with the oldest prediction. Mismatches are counted.
// ----------------------------------------------------------------------------
module cfr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [4:0]  req_hours,
   input  logic [5:0]  req_minutes,
   input  logic        req_alarm_on,
   input  logic [31:0] req_now_us,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_action,
   input  logic [1:0]  rsp_module_res,
   input  logic [2:0]  rsp_row,
   input  logic [7:0]  rsp_row_data,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          writes_pending
);

   typedef struct packed {
      logic       action;
      logic [1:0] module_res;
      logic [2:0] row;
      logic [7:0] row_data;
      logic       last;
   } led_write_type;

   localparam logic [7:0] NUMERALS [2][10][5] = '{
      '{
         '{8'h1F, 8'h21, 8'h42, 8'h84, 8'hF8},
         '{8'h20, 8'h23, 8'h4C, 8'h70, 8'hC0},
         '{8'h21, 8'h47, 8'hCA, 8'h72, 8'h04},
         '{8'h20, 8'h40, 8'h89, 8'hB2, 8'hCC},
         '{8'h18, 8'h68, 8'h93, 8'h3C, 8'h10},
         '{8'h32, 8'h49, 8'h51, 8'h91, 8'h0E},
         '{8'h0C, 8'h32, 8'h49, 8'h8A, 8'h04},
         '{8'h43, 8'h8C, 8'h90, 8'hA0, 8'hC0},
         '{8'h07, 8'h69, 8'h91, 8'hAE, 8'hC0},
         '{8'h01, 8'h61, 8'h96, 8'h98, 8'h60}
      },
      '{
         '{8'h00, 8'hFF, 8'h81, 8'hFF, 8'h00},
         '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00},
         '{8'h00, 8'h9F, 8'h91, 8'hF1, 8'h00},
         '{8'h00, 8'h91, 8'h91, 8'hFF, 8'h00},
         '{8'h00, 8'hF0, 8'h10, 8'hFF, 8'h00},
         '{8'h00, 8'hF1, 8'h91, 8'h9F, 8'h00},
         '{8'h00, 8'hFF, 8'h91, 8'h9F, 8'h00},
         '{8'h00, 8'h80, 8'h80, 8'hFF, 8'h00},
         '{8'h00, 8'hFF, 8'h91, 8'hFF, 8'h00},
         '{8'h00, 8'hF0, 8'h90, 8'hFF, 8'h00}
      }
   };

   localparam logic [7:0] CLOCK_ICON [9] = '{
      8'h40, 8'hB9, 8'h55, 8'h92, 8'hB2, 8'h82, 8'h45, 8'hB9, 8'h40
   };

   // index 0 draws OFF, index 1 draws ON
   localparam logic [7:0] ON_OFF [2][15] = '{
      '{8'h00, 8'h1C, 8'h22, 8'h42, 8'h44, 8'h38, 8'h00, 8'h02,
        8'h3C, 8'h50, 8'h40, 8'h02, 8'h3C, 8'h50, 8'h40},
      '{8'h00, 8'h1C, 8'h22, 8'h42, 8'h44, 8'h38, 8'h00, 8'h00,
        8'h1E, 8'h60, 8'h18, 8'h06, 8'h78, 8'h00, 8'h00}
   };

   logic [7:0]    panel_rows [cfr_pkg::ROWS];
   logic [7:0]    canvas [cfr_pkg::ROWS];
   logic          blink_shown;
   logic [31:0]   last_toggle_us;
   logic [31:0]   blink_gap_us;
   logic          font_sel;
   led_write_type led_writes_due [$];
   led_write_type batch [$];

   initial begin
      mismatches     = 0;
      writes_pending = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   function automatic void clear_panel();
      int r;
      for (r = 0; r < cfr_pkg::ROWS; r++) panel_rows[r] = '0;
   endfunction

   function automatic led_write_type make_write(input logic act, input int module_idx,
                                                input int row_idx, input logic [7:0] data);
      led_write_type w;
      w.action     = act;
      w.module_res = module_idx[1:0];
      w.row        = row_idx[2:0];
      w.row_data   = data;
      w.last       = 1'b0;
      return w;
   endfunction

   function automatic void plot_column(input int col, input logic [7:0] bits);
      int base;
      int bitpos;
      int i;
      base   = (col / 8) * 8;
      bitpos = 7 - (col % 8);
      for (i = 0; i < 8; i++) canvas[base + i][bitpos] = bits[7 - i];
   endfunction

   function automatic void plot_digit(input int col, input int digit);
      int k;
      for (k = 0; k < 5; k++) plot_column(col + k, NUMERALS[font_sel][digit][k]);
   endfunction

   function automatic void paint_time(input logic [4:0] hours, input logic [5:0] minutes);
      int hh;
      int mm;
      hh = (hours > 5'd23) ? 23 : int'(hours);
      mm = (minutes > 6'd59) ? 59 : int'(minutes);
      if (hh / 10 != 0) plot_digit(0, hh / 10);
      plot_digit(6, hh % 10);
      plot_digit(13, mm / 10);
      plot_digit(19, mm % 10);
   endfunction

   function automatic void collect_changes();
      int r;
      for (r = 0; r < cfr_pkg::ROWS; r++) begin
         if (canvas[r] != panel_rows[r]) begin
            batch.push_back(make_write(cfr_pkg::ACT_ROW, r / 8, r % 8, canvas[r]));
            panel_rows[r] = canvas[r];
         end
      end
   endfunction

   task automatic render_item(input logic [1:0] cmd, input logic [4:0] hours,
                              input logic [5:0] minutes, input logic alarm_on,
                              input logic [31:0] now_us);
      logic [31:0]   elapsed;
      led_write_type w;
      int            c;
      int            k;
      batch.delete();
      for (c = 0; c < cfr_pkg::ROWS; c++) canvas[c] = '0;
      case (cmd)
         cfr_pkg::CMD_TIME: begin
            paint_time(hours, minutes);
            collect_changes();
         end
         cfr_pkg::CMD_ALARM: begin
            for (c = 0; c < 9; c++) plot_column(c, CLOCK_ICON[c]);
            for (c = 9; c < cfr_pkg::ROWS; c++) plot_column(c, ON_OFF[alarm_on][c - 9]);
            collect_changes();
         end
         cfr_pkg::CMD_BLINK: begin
            elapsed = now_us - last_toggle_us;
            if (elapsed > blink_gap_us) begin
               if (!blink_shown) begin
                  paint_time(hours, minutes);
                  collect_changes();
                  blink_shown = 1'b1;
               end else begin
                  for (k = 0; k < cfr_pkg::MODULES; k++)
                     batch.push_back(make_write(cfr_pkg::ACT_CLEAR, k, 0, 8'h00));
                  clear_panel();
                  blink_shown = 1'b0;
               end
               last_toggle_us = now_us;
            end
         end
         default: ;
      endcase
      for (k = 0; k < batch.size(); k++) begin
         w      = batch[k];
         w.last = (k == batch.size() - 1);
         led_writes_due.push_back(w);
      end
   endtask

   always @(posedge clock) begin : monitor
      led_write_type want;
      if (reset) begin
         clear_panel();
         blink_shown    = 1'b0;
         last_toggle_us = '0;
         blink_gap_us   = cfr_pkg::BLINK_INTERVAL_RESET;
         font_sel       = cfr_pkg::FONT_STYLE_RESET;
         led_writes_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               cfr_pkg::REG_BLINK_INTERVAL: blink_gap_us = csr_wdata;
               cfr_pkg::REG_FONT_STYLE:     font_sel     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (led_writes_due.size() == 0) begin
               report_mismatch($sformatf(
                  "write with none expected: action %0d module %0d row %0d data 0x%0h",
                  rsp_action, rsp_module_res, rsp_row, rsp_row_data));
            end else begin
               want = led_writes_due.pop_front();
               compare_field("action", 32'(rsp_action), 32'(want.action));
               compare_field("module_res", 32'(rsp_module_res), 32'(want.module_res));
               compare_field("row", 32'(rsp_row), 32'(want.row));
               compare_field("row_data", 32'(rsp_row_data), 32'(want.row_data));
               compare_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && req_ready)
            render_item(req_command, req_hours, req_minutes, req_alarm_on, req_now_us);
      end
      writes_pending = led_writes_due.size();
   end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Clock face row renderer testbench
// Drives directed and random show-time, show-alarm, blink and unused-command
// items through several register settings with bursty input and a stalling
// receiver, and lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         BACKLOG_CYCLES = 250;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command  = '0;
   logic [4:0]  req_hours    = '0;
   logic [5:0]  req_minutes  = '0;
   logic        req_alarm_on = 1'b0;
   logic [31:0] req_now_us   = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic        rsp_action;
   logic [1:0]  rsp_module_res;
   logic [2:0]  rsp_row;
   logic [7:0]  rsp_row_data;
   logic        rsp_last;
   logic        csr_we       = 1'b0;
   logic        csr_index    = 1'b0;
   logic [31:0] csr_wdata    = '0;
   int          mismatches;
   int          writes_pending;
   int          backlog_asks = 0;
   int          backlog_done = 0;
   logic [31:0] wall_us      = '0;
   logic [31:0] cur_interval = cfr_pkg::BLINK_INTERVAL_RESET;

   always #6 clock = ~clock;

   clock_face_row_renderer_unit DUT (.*);

   cfr_checker watch (.*);

   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(input logic [1:0] cmd, input logic [4:0] hours,
                            input logic [5:0] minutes, input logic alarm_on,
                            input logic [31:0] now_us);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_hours    <= hours;
      req_minutes  <= minutes;
      req_alarm_on <= alarm_on;
      req_now_us   <= now_us;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic sender_gap(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == cfr_pkg::REG_BLINK_INTERVAL) cur_interval = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drive_ready(input int n, input int pct);
      repeat (n) begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) < pct);
      end
   endtask

   task automatic send_random(input int n);
      int          sent;
      int          burst;
      int          pick;
      logic [1:0]  cmd;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [31:0] now_us;
      sent = 0;
      while (sent < n) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
         repeat (burst) begin
            pick    = $urandom_range(0, 99);
            hours   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                                  : 5'($urandom_range(0, 23));
            minutes = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
                                                  : 6'($urandom_range(0, 59));
            now_us  = $urandom;
            if (pick < 38) begin
               cmd = cfr_pkg::CMD_TIME;
            end else if (pick < 58) begin
               cmd = cfr_pkg::CMD_ALARM;
            end else if (pick < 95) begin
               cmd = cfr_pkg::CMD_BLINK;
               case ($urandom_range(0, 9))
                  0:       wall_us = $urandom;
                  1, 2, 3: wall_us = wall_us + $urandom_range(0, cur_interval >> 1);
                  default: wall_us = wall_us + cur_interval + $urandom_range(0, 3);
               endcase
               now_us = wall_us;
            end else begin
               cmd = CMD_UNUSED;
            end
            send_item(cmd, hours, minutes, 1'($urandom_range(0, 1)), now_us);
            if (cmd != CMD_UNUSED) sent++;
         end
         if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 6));
      end
   endtask

   initial begin : receiver
      forever begin
         if (backlog_asks != backlog_done) begin
            drive_ready(BACKLOG_CYCLES, 0);
            backlog_done++;
         end else begin
            case ($urandom_range(0, 3))
               0: drive_ready($urandom_range(10, 60), 100);
               1: drive_ready($urandom_range(20, 60), 50);
               2: begin
                  repeat ($urandom_range(3, 10)) begin
                     drive_ready($urandom_range(1, 3), 100);
                     drive_ready($urandom_range(1, 6), 0);
                  end
               end
               default: drive_ready($urandom_range(20, 80), 75);
            endcase
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(cfr_pkg::CMD_TIME, 5'd0, 6'd0, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd23, 6'd59, 1'b1, 32'hFFFF_FFFF);
      send_item(cfr_pkg::CMD_TIME, 5'd31, 6'd63, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd24, 6'd60, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd9, 6'd5, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd10, 6'd10, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd20, 6'd47, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_ALARM, 5'd0, 6'd0, 1'b1, 32'd0);
      send_item(cfr_pkg::CMD_ALARM, 5'd31, 6'd63, 1'b0, 32'hFFFF_FFFF);
      send_item(cfr_pkg::CMD_ALARM, 5'd0, 6'd0, 1'b0, 32'd0);
      send_item(CMD_UNUSED, 5'd31, 6'd63, 1'b1, 32'hFFFF_FFFF);
      send_item(cfr_pkg::CMD_BLINK, 5'd12, 6'd34, 1'b0, 32'd500000);
      send_item(cfr_pkg::CMD_BLINK, 5'd12, 6'd34, 1'b0, 32'd500001);
      send_item(cfr_pkg::CMD_BLINK, 5'd12, 6'd34, 1'b0, 32'd600000);
      send_item(cfr_pkg::CMD_BLINK, 5'd12, 6'd34, 1'b0, 32'd1000002);
      send_item(cfr_pkg::CMD_BLINK, 5'd31, 6'd63, 1'b1, 32'd1000001);
      send_item(cfr_pkg::CMD_BLINK, 5'd0, 6'd0, 1'b0, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd31, 6'd0, 1'b1, 32'd0);
      send_item(cfr_pkg::CMD_TIME, 5'd0, 6'd63, 1'b0, 32'd0);
      drain();

      write_reg(cfr_pkg::REG_BLINK_INTERVAL, 32'd0);
      write_reg(cfr_pkg::REG_FONT_STYLE, 32'd0);
      send_random(50);
      drain();
      send_random(55);
      drain();

      write_reg(cfr_pkg::REG_BLINK_INTERVAL, 32'hFFFF_FFFF);
      write_reg(cfr_pkg::REG_FONT_STYLE, 32'd1);
      send_random(105);
      drain();

      write_reg(cfr_pkg::REG_FONT_STYLE, 32'd0);
      write_reg(cfr_pkg::REG_BLINK_INTERVAL, 32'd1000);
      send_random(20);
      backlog_asks++;
      send_random(85);
      drain();

      write_reg(cfr_pkg::REG_BLINK_INTERVAL, $urandom_range(1, 60000));
      write_reg(cfr_pkg::REG_FONT_STYLE, 32'd1);
      send_random(50);
      backlog_asks++;
      send_random(55);
      drain();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cfr_pkg.sv
hdl/cfr_row_gen.sv
hdl/clock_face_row_renderer_unit.sv
hdl/cfr_checker.sv
test/cfr_checker.sv
test/tb.sv
